[rtl/frame_difference_activity_defines.svh]
// Assertion macros shared by the frame difference activity RTL.
// Used by the modules that carry concurrent checks; no other dependencies.
`ifndef FRAME_DIFFERENCE_ACTIVITY_DEFINES_SVH
`define FRAME_DIFFERENCE_ACTIVITY_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, sampled on clk, idle while arst_n is low.
`define FDA_ASSERT_NOW(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("check failed: same-cycle implication");

// Next-cycle implication, sampled on clk, idle while arst_n is low.
`define FDA_ASSERT_NEXT(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("check failed: next-cycle implication");

`else

`define FDA_ASSERT_NOW(label, pre, post)
`define FDA_ASSERT_NEXT(label, pre, post)

`endif

`endif

[rtl/fda_pkg.sv]
// Shared constants, register codes and handshake structs for the frame difference block.
// No dependencies; every RTL module of the block imports it.
package fda_pkg;

	// Frame store geometry.
	localparam int MAX_PIXELS = 131072;
	localparam int IDX_W      = $clog2(MAX_PIXELS);
	localparam int CNT_W      = IDX_W + 1;
	localparam int PIX_W      = 8;

	// Activity fraction in Q0.16, one extra bit so that a full frame reads as 1.0.
	localparam int FRAC_BITS = 16;
	localparam int FRAC_W    = FRAC_BITS + 1;
	localparam int STEP_W    = $clog2(FRAC_BITS);
	localparam logic [FRAC_W-1:0] FRAC_ONE = FRAC_W'(1) << FRAC_BITS;

	// Configuration port.
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam logic [PIX_W-1:0] THRESHOLD_RESET    = PIX_W'(30);
	localparam logic [CNT_W-1:0] FRAME_PIXELS_RESET = CNT_W'(76800);
	localparam logic [CNT_W-1:0] LEN_MAX            = CNT_W'(MAX_PIXELS);

	// Register index, taken from the word address bit of paddr.
	typedef enum logic [0:0] {
		REG_THRESHOLD    = 1'b0,
		REG_FRAME_PIXELS = 1'b1
	} reg_idx_t;

	// End-of-frame request to the divider.
	typedef struct packed {
		logic [CNT_W-1:0] count;
		logic [CNT_W-1:0] len;
	} div_req_t;

	// Finished frame result.
	typedef struct packed {
		logic [CNT_W-1:0]  changed;
		logic [FRAC_W-1:0] fraction;
	} div_res_t;

endpackage

[rtl/fda_frame_store.sv]
// Previous-frame pixel memory: one write port and one read port with registered read data.
// Depends on fda_pkg for the depth and widths.
module fda_frame_store (
	input  logic                     clk,
	input  logic                     we,
	input  logic [fda_pkg::IDX_W-1:0] waddr,
	input  logic [fda_pkg::PIX_W-1:0] wdata,
	input  logic                     re,
	input  logic [fda_pkg::IDX_W-1:0] raddr,
	output logic [fda_pkg::PIX_W-1:0] rdata
);
	import fda_pkg::*;

	logic [PIX_W-1:0] mem [MAX_PIXELS];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port; data holds until the next read.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[rtl/fda_divider.sv]
// Iterative divider for the activity fraction: one quotient bit per cycle, with saturation at 1.0.
// Depends on fda_pkg and the assertion macros header.
`include "frame_difference_activity_defines.svh"

module fda_divider (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  fda_pkg::div_req_t   req,
	output logic                res_valid,
	input  logic                res_take,
	output fda_pkg::div_res_t   res
);
	import fda_pkg::*;

	typedef enum logic [2:0] {
		DIV_IDLE = 3'b001,
		DIV_RUN  = 3'b010,
		DIV_DONE = 3'b100
	} div_state_t;

	localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(FRAC_BITS - 1);

	div_state_t         state_q;
	logic [CNT_W-1:0]   rem_q;
	logic [CNT_W-1:0]   div_q;
	logic [FRAC_BITS-1:0] quo_q;
	logic [STEP_W-1:0]  step_q;
	logic [CNT_W-1:0]   changed_q;
	logic [FRAC_W-1:0]  frac_q;

	logic [CNT_W:0]       trial;
	logic                 fits;
	logic [CNT_W-1:0]     rem_next;
	logic [FRAC_BITS-1:0] quo_next;

	// One restoring step: shift the remainder, subtract the frame length if it fits.
	always_comb begin
		trial    = {rem_q, 1'b0};
		fits     = trial >= {1'b0, div_q};
		rem_next = fits ? CNT_W'(trial - {1'b0, div_q}) : trial[CNT_W-1:0];
		quo_next = {quo_q[FRAC_BITS-2:0], fits};
	end

	// Control sequence.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= DIV_IDLE;
			step_q  <= '0;
		end else begin
			unique case (state_q)
				DIV_IDLE: begin
					if (req_valid) begin
						step_q  <= '0;
						state_q <= (req.count >= req.len) ? DIV_DONE : DIV_RUN;
					end
				end
				DIV_RUN: begin
					step_q <= step_q + STEP_W'(1);
					if (step_q == STEP_LAST) begin
						state_q <= DIV_DONE;
					end
				end
				DIV_DONE: begin
					if (res_take) begin
						state_q <= DIV_IDLE;
					end
				end
				default: state_q <= DIV_IDLE;
			endcase
		end
	end

	// Datapath. A count at or above the frame length saturates to 1.0.
	always_ff @(posedge clk) begin
		if (state_q == DIV_IDLE && req_valid) begin
			changed_q <= req.count;
			div_q     <= req.len;
			rem_q     <= req.count;
			quo_q     <= '0;
			frac_q    <= FRAC_ONE;
		end else if (state_q == DIV_RUN) begin
			rem_q <= rem_next;
			quo_q <= quo_next;
			if (step_q == STEP_LAST) begin
				frac_q <= {1'b0, quo_next};
			end
		end
	end

	assign req_ready    = (state_q == DIV_IDLE);
	assign res_valid    = (state_q == DIV_DONE);
	assign res.changed  = changed_q;
	assign res.fraction = frac_q;

	// The running remainder stays below the divisor.
	`FDA_ASSERT_NOW(a_rem_below_len, state_q == DIV_RUN, rem_q < div_q)
	// A finished fraction never exceeds 1.0.
	`FDA_ASSERT_NOW(a_frac_range, state_q == DIV_DONE, frac_q <= FRAC_ONE)
	// A started division finishes after one quotient bit per cycle.
	`FDA_ASSERT_NEXT(a_run_ends, state_q == DIV_RUN && step_q == STEP_LAST, state_q == DIV_DONE)

endmodule

[rtl/frame_difference_activity.sv]
// Frame difference activity meter. A pixel is read from the frame store at acceptance and
// compared in the next cycle; a frame's count goes to the divider, which saturates or runs its
// restoring steps, and its result is registered at the output. Throughput: one pixel per cycle;
// the last pixel of a frame waits while the divider is still busy with the previous frame.
// Reset (arst_n, asynchronous) restores the register defaults and clears index, count and the
// frame store fill count: entries not yet written since reset read as zero, with no clear pass.
`include "frame_difference_activity_defines.svh"

module frame_difference_activity (
	input  logic                        clk,
	input  logic                        arst_n,
	// Pixel channel
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [fda_pkg::PIX_W-1:0]   gray_value,
	input  logic                        frame_start,
	// Result channel
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [fda_pkg::CNT_W-1:0]   changed_pixels,
	output logic [fda_pkg::FRAC_W-1:0]  activity_fraction,
	// Configuration port
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [fda_pkg::PADDR_W-1:0] paddr,
	input  logic [fda_pkg::PDATA_W-1:0] pwdata,
	output logic [fda_pkg::PDATA_W-1:0] prdata,
	output logic                        pready
);
	import fda_pkg::*;

	// Configuration registers.
	logic [PIX_W-1:0] threshold_q;
	logic [CNT_W-1:0] frame_pixels_q;
	reg_idx_t         reg_idx;
	logic             cfg_write;

	// Frame progress.
	logic [IDX_W-1:0] idx_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] fill_q;

	// Compare stage.
	logic             valid_s1;
	logic [PIX_W-1:0] gray_s1;
	logic             start_s1;
	logic [IDX_W-1:0] idx_s1;
	logic             hit_s1;
	logic             fwd_s1;
	logic [PIX_W-1:0] fwd_data_s1;

	// Output register.
	logic             out_valid_q;
	logic [CNT_W-1:0] changed_q;
	logic [FRAC_W-1:0] fraction_q;

	logic             accept;
	logic [IDX_W-1:0] acc_idx;
	logic [IDX_W-1:0] next_idx;
	logic [CNT_W-1:0] len;
	logic [CNT_W-1:0] idx_plus;
	logic             last_s1;
	logic             s1_go;
	logic [PIX_W-1:0] rdata;
	logic [PIX_W-1:0] stored;
	logic [PIX_W-1:0] diff;
	logic             changed;
	logic [CNT_W-1:0] count_new;

	logic      div_req_valid;
	logic      div_req_ready;
	div_req_t  div_req;
	logic      div_res_valid;
	logic      div_res_take;
	div_res_t  div_res;

	// Register write decode and read mux.
	assign pready    = 1'b1;
	assign reg_idx   = reg_idx_t'(paddr[2]);
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q    <= THRESHOLD_RESET;
			frame_pixels_q <= FRAME_PIXELS_RESET;
		end else if (cfg_write) begin
			unique case (reg_idx)
				REG_THRESHOLD:    threshold_q    <= pwdata[PIX_W-1:0];
				REG_FRAME_PIXELS: frame_pixels_q <= pwdata[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_THRESHOLD:    prdata = {{(PDATA_W-PIX_W){1'b0}}, threshold_q};
			REG_FRAME_PIXELS: prdata = {{(PDATA_W-CNT_W){1'b0}}, frame_pixels_q};
			default:          prdata = '0;
		endcase
	end

	// Effective frame length: zero counts as one, large values clamp to the store depth.
	always_comb begin
		if (frame_pixels_q == '0) begin
			len = CNT_W'(1);
		end else if (frame_pixels_q > LEN_MAX) begin
			len = LEN_MAX;
		end else begin
			len = frame_pixels_q;
		end
	end

	// End of frame and stage advance. The last pixel waits for a free divider.
	assign idx_plus = {1'b0, idx_s1} + CNT_W'(1);
	assign last_s1  = idx_plus >= len;
	assign s1_go    = valid_s1 && (!last_s1 || div_req_ready);
	assign in_ready = !valid_s1 || s1_go;
	assign accept   = in_valid && in_ready;

	// Address of the incoming pixel, following the one that completes this cycle.
	always_comb begin
		if (valid_s1) begin
			next_idx = last_s1 ? '0 : idx_plus[IDX_W-1:0];
		end else begin
			next_idx = idx_q;
		end
		acc_idx = frame_start ? '0 : next_idx;
	end

	fda_frame_store u_store (
		.clk   (clk),
		.we    (s1_go),
		.waddr (idx_s1),
		.wdata (gray_s1),
		.re    (accept),
		.raddr (acc_idx),
		.rdata (rdata)
	);

	// Stage register. Entries at or above the fill count were never written and read as zero;
	// a read of the entry being written this cycle takes the new pixel instead.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			gray_s1     <= gray_value;
			start_s1    <= frame_start;
			idx_s1      <= acc_idx;
			hit_s1      <= {1'b0, acc_idx} < fill_q;
			fwd_s1      <= valid_s1 && (acc_idx == idx_s1);
			fwd_data_s1 <= gray_s1;
		end
	end

	// Compare against the previous frame.
	always_comb begin
		if (fwd_s1) begin
			stored = fwd_data_s1;
		end else if (hit_s1) begin
			stored = rdata;
		end else begin
			stored = '0;
		end
		diff      = (gray_s1 >= stored) ? (gray_s1 - stored) : (stored - gray_s1);
		changed   = diff > threshold_q;
		count_new = (start_s1 ? '0 : count_q) + CNT_W'(changed);
	end

	// Frame progress and the written-prefix fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			count_q <= '0;
			fill_q  <= '0;
		end else if (s1_go) begin
			idx_q   <= last_s1 ? '0 : idx_plus[IDX_W-1:0];
			count_q <= last_s1 ? '0 : count_new;
			if ({1'b0, idx_s1} == fill_q) begin
				fill_q <= fill_q + CNT_W'(1);
			end
		end
	end

	// Fraction of changed pixels, computed once per frame.
	assign div_req_valid = s1_go && last_s1;
	assign div_req.count = count_new;
	assign div_req.len   = len;
	assign div_res_take  = div_res_valid && (!out_valid_q || out_ready);

	fda_divider u_divider (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (div_req_valid),
		.req_ready (div_req_ready),
		.req       (div_req),
		.res_valid (div_res_valid),
		.res_take  (div_res_take),
		.res       (div_res)
	);

	// Output register for the result word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (div_res_take) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (div_res_take) begin
			changed_q  <= div_res.changed;
			fraction_q <= div_res.fraction;
		end
	end

	assign out_valid         = out_valid_q;
	assign changed_pixels    = changed_q;
	assign activity_fraction = fraction_q;

	// The fill count never passes the store depth.
	`FDA_ASSERT_NOW(a_fill_range, 1'b1, fill_q <= LEN_MAX)
	// Writes only ever extend the written prefix by one entry.
	`FDA_ASSERT_NOW(a_prefix, valid_s1, {1'b0, idx_s1} <= fill_q)
	// Only the last pixel of a frame can stall the compare stage.
	`FDA_ASSERT_NOW(a_stall_last, valid_s1 && !s1_go, last_s1)
	// A completed pixel that does not end the frame advances the index by one.
	`FDA_ASSERT_NEXT(a_index_step, s1_go && !last_s1, {1'b0, idx_q} == $past(idx_plus))

endmodule

[tb/frame_difference_activity_tb.sv]
// Self-checking testbench for frame_difference_activity: it sends pixel words and register
// writes, predicts every frame result from a shadow frame store and checks each result word.
// Depends on fda_pkg and the frame_difference_activity RTL only.
module frame_difference_activity_tb;
	import fda_pkg::*;

	localparam int LIMIT_CYCLES       = 1500000;
	localparam int SETTLE_CYCLES      = 24;
	localparam int RANDOM_PIXELS      = 900;
	localparam int FIRST_FRAME_PIXELS = 256;
	localparam int OVERSIZE_PIXELS    = 200;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic [PIX_W-1:0] gray_value;
	logic frame_start;
	logic out_valid;
	logic out_ready;
	logic [CNT_W-1:0] changed_pixels;
	logic [FRAC_W-1:0] activity_fraction;
	logic psel;
	logic penable;
	logic pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic pready;

	// Shadow copy of the block state used to predict frame results.
	bit [PIX_W-1:0] shadow_frame [MAX_PIXELS];
	int unsigned shadow_index = 0;
	int unsigned shadow_count = 0;
	logic [PIX_W-1:0] shadow_threshold = THRESHOLD_RESET;
	logic [CNT_W-1:0] shadow_frame_pixels = FRAME_PIXELS_RESET;
	div_res_t expected_reports[$];
	div_res_t checked_report;

	int unsigned mismatch_count = 0;
	int unsigned cycle_count = 0;
	bit tx_gaps_on = 1'b1;
	bit rx_gaps_on = 1'b1;
	int unsigned rx_hold_request = 0;

	frame_difference_activity dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.gray_value(gray_value),
		.frame_start(frame_start),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.changed_pixels(changed_pixels),
		.activity_fraction(activity_fraction),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Frame length as the block uses it: zero counts as one, oversize saturates.
	function automatic int unsigned frame_length();
		int unsigned n;
		n = 32'(shadow_frame_pixels);
		if (n == 0)
			n = 1;
		if (n > MAX_PIXELS)
			n = MAX_PIXELS;
		return n;
	endfunction

	// Update the shadow state for one accepted pixel and queue the frame result if it ends one.
	function automatic void predict_activity(input logic [PIX_W-1:0] gray, input logic start);
		int unsigned len;
		int unsigned stored;
		int unsigned diff;
		longint unsigned frac;
		div_res_t report;
		len = frame_length();
		stored = 0;
		if (start) begin
			shadow_index = 0;
			shadow_count = 0;
		end
		if (shadow_index < MAX_PIXELS) begin
			stored = 32'(shadow_frame[shadow_index]);
			shadow_frame[shadow_index] = gray;
		end
		diff = (gray >= stored) ? (gray - stored) : (stored - gray);
		if (diff > shadow_threshold)
			shadow_count++;
		if (shadow_index + 1 >= len) begin
			frac = (longint'(shadow_count) << FRAC_BITS) / len;
			if (frac > FRAC_ONE)
				frac = FRAC_ONE;
			report.changed = CNT_W'(shadow_count);
			report.fraction = FRAC_W'(frac);
			expected_reports.insert(expected_reports.size(), report);
			shadow_index = 0;
			shadow_count = 0;
		end else begin
			shadow_index++;
		end
	endfunction

	// Gap length for either side: mostly none, some short, a few long.
	function automatic int unsigned pick_gap(input bit enabled);
		int unsigned r;
		if (!enabled)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 70)
			return 0;
		if (r < 94)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Pixel value aimed at the threshold boundary against the stored pixel, at the extremes, at random or equal to it.
	function automatic logic [PIX_W-1:0] next_gray(input logic start);
		int stored;
		int step;
		int v;
		stored = int'(shadow_frame[start ? 0 : shadow_index]);
		case ($urandom_range(0, 9))
			0, 1, 2, 3: begin
				step = int'(shadow_threshold) + int'($urandom_range(0, 2)) - 1;
				v = $urandom_range(0, 1) ? stored + step : stored - step;
			end
			4, 5: v = $urandom_range(0, 255);
			6: v = 0;
			7: v = 255;
			default: v = stored;
		endcase
		if (v < 0)
			v = 0;
		if (v > 255)
			v = 255;
		return v[PIX_W-1:0];
	endfunction

	// Send one pixel word and wait for its acceptance.
	task automatic send_pixel(input logic [PIX_W-1:0] gray, input logic start);
		int unsigned gap;
		gap = pick_gap(tx_gaps_on);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		gray_value <= gray;
		frame_start <= start;
		do @(posedge clk); while (!in_ready);
		predict_activity(gray, start);
	endtask

	// One access on the register port, setup phase then access phase; the bus stays selected afterwards.
	task automatic apb_access(input reg_idx_t idx, input logic do_write,
			input logic [PDATA_W-1:0] value, output logic [PDATA_W-1:0] rdata);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= do_write;
		paddr <= PADDR_W'({idx, 2'b00});
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		if (do_write) begin
			case (idx)
				REG_THRESHOLD: shadow_threshold = value[PIX_W-1:0];
				REG_FRAME_PIXELS: shadow_frame_pixels = value[CNT_W-1:0];
				default: ;
			endcase
		end
	endtask

	task automatic write_config(input logic [PIX_W-1:0] thr, input logic [CNT_W-1:0] len);
		logic [PDATA_W-1:0] unused;
		apb_access(REG_THRESHOLD, 1'b1, PDATA_W'(thr), unused);
		apb_access(REG_FRAME_PIXELS, 1'b1, PDATA_W'(len), unused);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	function automatic void check_readback(input string name, input logic [PDATA_W-1:0] got,
			input logic [PDATA_W-1:0] want);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatch_count++;
		end
	endfunction

	// Wait until every frame result has arrived and the block has had time to settle.
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (expected_reports.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Reset values read back, then the largest value of each register written and read back before the defaults return.
	task automatic test_reset_registers();
		logic [PDATA_W-1:0] got;
		apb_access(REG_THRESHOLD, 1'b0, '0, got);
		check_readback("change_threshold", got, PDATA_W'(THRESHOLD_RESET));
		apb_access(REG_FRAME_PIXELS, 1'b0, '0, got);
		check_readback("frame_pixels", got, PDATA_W'(FRAME_PIXELS_RESET));
		apb_access(REG_THRESHOLD, 1'b1, PDATA_W'(8'hFF), got);
		apb_access(REG_FRAME_PIXELS, 1'b1, PDATA_W'(18'h3FFFF), got);
		apb_access(REG_THRESHOLD, 1'b0, '0, got);
		check_readback("change_threshold", got, PDATA_W'(8'hFF));
		apb_access(REG_FRAME_PIXELS, 1'b0, '0, got);
		check_readback("frame_pixels", got, PDATA_W'(18'h3FFFF));
		apb_access(REG_THRESHOLD, 1'b1, PDATA_W'(THRESHOLD_RESET), got);
		apb_access(REG_FRAME_PIXELS, 1'b1, PDATA_W'(FRAME_PIXELS_RESET), got);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// First frame, at the default threshold, is compared against the unwritten store, which reads as zero.
	task automatic test_first_frame_against_black();
		write_config(THRESHOLD_RESET, CNT_W'(FIRST_FRAME_PIXELS));
		tx_gaps_on = 1'b0;
		for (int i = 0; i < FIRST_FRAME_PIXELS; i++)
			send_pixel(PIX_W'($urandom_range(0, 255)), i == 0);
		wait_drained();
		tx_gaps_on = 1'b1;
	endtask

	// Threshold extremes, zero length, restart mid-frame and a length lowered mid-frame.
	task automatic test_corner_cases();
		write_config(8'd0, CNT_W'(4));
		send_pixel(8'd255, 1'b1);
		send_pixel(8'd0, 1'b0);
		send_pixel(shadow_frame[2], 1'b0);
		send_pixel(shadow_frame[3] == 8'd255 ? 8'd254 : shadow_frame[3] + 8'd1, 1'b0);
		wait_drained();

		// No difference can exceed the largest threshold.
		write_config(8'd255, CNT_W'(2));
		send_pixel(8'd0, 1'b1);
		send_pixel(8'd255, 1'b0);
		wait_drained();

		// A zero length makes every pixel a frame of its own.
		write_config(8'd10, CNT_W'(0));
		send_pixel(8'd200, 1'b1);
		send_pixel(8'd0, 1'b0);
		send_pixel(8'd255, 1'b0);
		wait_drained();

		// Frame start in the middle of a frame restarts the count.
		write_config(8'd10, CNT_W'(5));
		send_pixel(8'd100, 1'b1);
		send_pixel(8'd50, 1'b0);
		send_pixel(8'd7, 1'b1);
		send_pixel(8'd9, 1'b0);
		send_pixel(8'd250, 1'b0);
		send_pixel(8'd1, 1'b0);
		send_pixel(8'd128, 1'b0);
		wait_drained();

		// Shrinking the length past the current index ends the frame with a saturated fraction.
		write_config(8'd0, CNT_W'(12));
		for (int i = 0; i < 6; i++)
			send_pixel(shadow_frame[i] < 8'd128 ? 8'd255 : 8'd0, i == 0);
		wait_drained();
		write_config(8'd0, CNT_W'(3));
		send_pixel(shadow_frame[6] < 8'd128 ? 8'd255 : 8'd0, 1'b0);
		wait_drained();
	endtask

	// An oversize length saturates to the full store, so a long run of pixels ends no frame;
	// lowering the length afterwards closes the frame.
	task automatic test_largest_frame();
		write_config(PIX_W'($urandom_range(0, 255)), CNT_W'(18'h3FFFF));
		tx_gaps_on = 1'b0;
		for (int i = 0; i < OVERSIZE_PIXELS; i++)
			send_pixel(next_gray(i == 0), i == 0);
		wait_drained();
		tx_gaps_on = 1'b1;
		write_config(shadow_threshold, CNT_W'(OVERSIZE_PIXELS));
		send_pixel(next_gray(1'b0), 1'b0);
		wait_drained();
	endtask

	// The receiver holds off for a long stretch while one-pixel frames keep coming.
	task automatic test_output_backpressure();
		write_config(8'd40, CNT_W'(1));
		tx_gaps_on = 1'b0;
		rx_hold_request = 400;
		repeat (80)
			send_pixel(PIX_W'($urandom_range(0, 255)), 1'b1);
		wait_drained();
		tx_gaps_on = 1'b1;
	endtask

	// Phases of mostly well formed frames with random content and settings.
	task automatic test_random_frames();
		int unsigned sent;
		int unsigned burst;
		logic start;
		logic [PIX_W-1:0] thr;
		logic [CNT_W-1:0] len;
		sent = 0;
		while (sent < RANDOM_PIXELS) begin
			wait_drained();
			if ($urandom_range(0, 4) != 0) begin
				case ($urandom_range(0, 9))
					0: thr = 8'd0;
					1: thr = 8'd255;
					2, 3, 4, 5: thr = PIX_W'($urandom_range(0, 40));
					default: thr = PIX_W'($urandom_range(0, 255));
				endcase
				case ($urandom_range(0, 9))
					0: len = '0;
					1: len = CNT_W'(1);
					2, 3, 4, 5, 6, 7: len = CNT_W'($urandom_range(2, 24));
					default: len = CNT_W'($urandom_range(25, 200));
				endcase
				write_config(thr, len);
			end
			tx_gaps_on = $urandom_range(0, 3) != 0;
			rx_gaps_on = $urandom_range(0, 3) != 0;
			burst = $urandom_range(40, 160);
			repeat (burst) begin
				if (shadow_index == 0)
					start = $urandom_range(0, 9) != 0;
				else
					start = $urandom_range(0, 32) == 0;
				send_pixel(next_gray(start), start);
			end
			sent += burst;
		end
		tx_gaps_on = 1'b1;
		rx_gaps_on = 1'b1;
	endtask

	// Result side: random stalls, plus a long hold-off when a test asks for one.
	initial begin
		int unsigned stall_left;
		stall_left = 0;
		out_ready <= 1'b0;
		do @(posedge clk); while (!arst_n);
		forever begin
			if (rx_hold_request != 0) begin
				stall_left = rx_hold_request;
				rx_hold_request = 0;
			end
			if (stall_left != 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else if (rx_gaps_on && $urandom_range(0, 99) < 15) begin
				out_ready <= 1'b0;
				stall_left = pick_gap(1'b1);
				if (stall_left != 0)
					stall_left--;
			end else begin
				out_ready <= 1'b1;
			end
			@(posedge clk);
		end
	end

	// Compare each accepted result word with the oldest expected frame result.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_reports.size() == 0) begin
				$error("unexpected result word: changed_pixels %0d, activity_fraction %0d",
					changed_pixels, activity_fraction);
				mismatch_count++;
			end else begin
				checked_report = expected_reports.pop_front();
				if (changed_pixels !== checked_report.changed) begin
					$error("changed_pixels: expected %0d, got %0d",
						checked_report.changed, changed_pixels);
					mismatch_count++;
				end
				if (activity_fraction !== checked_report.fraction) begin
					$error("activity_fraction: expected %0d, got %0d",
						checked_report.fraction, activity_fraction);
					mismatch_count++;
				end
			end
		end
	end

	// Watchdog against a hung handshake.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		gray_value <= '0;
		frame_start <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_registers();
		test_first_frame_against_black();
		test_corner_cases();
		test_largest_frame();
		test_output_backpressure();
		test_random_frames();
		wait_drained();

		if (mismatch_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

[sim.f]
+incdir+rtl
rtl/fda_pkg.sv
rtl/fda_frame_store.sv
rtl/fda_divider.sv
rtl/frame_difference_activity.sv
tb/frame_difference_activity_tb.sv
